// ----- sv/fppa_pkg.sv -----
// package: payload types, cordic constants and helpers for the phase power accumulator
`default_nettype none
package fppa_pkg;

	localparam int MAX_POINTS = 4096;
	localparam int CORDIC_STAGES = 16;
	localparam int COUNT_W = 13;
	localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;
	localparam logic [47:0] INTENSITY_MAX = 48'hFFFF_FFFF_FFFF;

	localparam logic [1:0] REG_Q_X = 2'd0;
	localparam logic [1:0] REG_Q_Y = 2'd1;
	localparam logic [1:0] REG_SCALE = 2'd2;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	typedef struct packed {
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic               is_last;
	} in_t;

	typedef struct packed {
		logic [47:0]        intensity;
		logic [COUNT_W-1:0] point_count;
		logic               saturated;
	} out_t;

	// one word in flight through the rotator cells
	typedef struct packed {
		logic               valid;
		logic               last;
		logic [1:0]         quad;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} cord_t;

	// accumulated set handed to the power stages
	typedef struct packed {
		logic               valid;
		logic signed [31:0] c;
		logic signed [31:0] s;
		logic [COUNT_W-1:0] count;
		logic               sat;
	} snap_t;

	// arctangent of 2^-i in 2^-32 turn
	function automatic logic signed [31:0] arc_at(input int i);
		logic signed [31:0] r;
		begin
			unique case (i)
				0: r = 32'sd536870912;
				1: r = 32'sd316933406;
				2: r = 32'sd167458907;
				3: r = 32'sd85004756;
				4: r = 32'sd42667331;
				5: r = 32'sd21354466;
				6: r = 32'sd10679838;
				7: r = 32'sd5340245;
				8: r = 32'sd2670163;
				9: r = 32'sd1335087;
				10: r = 32'sd667544;
				11: r = 32'sd333772;
				12: r = 32'sd166886;
				13: r = 32'sd83443;
				14: r = 32'sd41722;
				15: r = 32'sd20861;
				16: r = 32'sd10430;
				17: r = 32'sd5215;
				18: r = 32'sd2608;
				19: r = 32'sd1304;
				20: r = 32'sd652;
				21: r = 32'sd326;
				22: r = 32'sd163;
				23: r = 32'sd81;
				default: r = 32'sd0;
			endcase
			return r;
		end
	endfunction

	function automatic logic signed [15:0] clamp16(input logic signed [17:0] v);
		logic signed [15:0] r;
		begin
			if (v > 18'sd32767) r = 16'sd32767;
			else if (v < -18'sd32768) r = -16'sd32768;
			else r = v[15:0];
			return r;
		end
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [32:0] v);
		logic signed [31:0] r;
		begin
			if (v > 33'sd2147483647) r = 32'sh7FFF_FFFF;
			else if (v < -33'sd2147483648) r = 32'sh8000_0000;
			else r = v[31:0];
			return r;
		end
	endfunction

endpackage
`default_nettype wire

// ----- sv/fppa_cell.sv -----
// one cordic rotation cell of the chain
`default_nettype none
module fppa_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [4:0]         shift,
	input  wire logic signed [31:0] arc,
	input  wire fppa_pkg::cord_t    d,
	output fppa_pkg::cord_t         q
);
	logic signed [31:0] dx;
	logic signed [31:0] dy;
	fppa_pkg::cord_t    nxt;

	always_comb begin
		dx = d.y >>> shift;
		dy = d.x >>> shift;
		nxt = d;
		if (!d.z[31]) begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - arc;
		end else begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + arc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else begin
			q <= nxt;
		end
	end
endmodule
`default_nettype wire

// ----- sv/fppa_power.sv -----
// squares the sums, scales them and holds the result word for the output
`default_nettype none
module fppa_power (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fppa_pkg::snap_t snap,
	input  wire logic [31:0]     scale,
	input  wire logic            out_stall,
	output logic                 out_valid,
	output fppa_pkg::out_t       out_data,
	output logic                 done
);
	logic v1_s1, v2_s2, v3_s3;
	logic [63:0] sq_c_s1, sq_s_s1, mag_s2, hi_s3, lo_s3;
	logic [fppa_pkg::COUNT_W-1:0] cnt_s1, cnt_s2, cnt_s3;
	logic sat_s1, sat_s2, sat_s3;
	logic advance;
	logic [64:0] total;
	logic out_valid_q;
	fppa_pkg::out_t out_q;

	// all stages wait while the last one holds a word and the previous word is still unclaimed
	assign advance = !(v3_s3 && out_valid_q && out_stall);
	assign done = v3_s3 && advance;
	assign total = {1'b0, hi_s3} + 65'(lo_s3[63:32]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				v1_s1 <= snap.valid;
				v2_s2 <= v1_s1;
				v3_s3 <= v2_s2;
			end
			if (done) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			// signed 32 by 32 squares, full 64 bit products
			sq_c_s1 <= 64'(snap.c) * 64'(snap.c);
			sq_s_s1 <= 64'(snap.s) * 64'(snap.s);
			cnt_s1 <= snap.count;
			sat_s1 <= snap.sat;
			mag_s2 <= sq_c_s1 + sq_s_s1;
			cnt_s2 <= cnt_s1;
			sat_s2 <= sat_s1;
			hi_s3 <= 64'(mag_s2[63:32]) * 64'(scale);
			lo_s3 <= 64'(mag_s2[31:0]) * 64'(scale);
			cnt_s3 <= cnt_s2;
			sat_s3 <= sat_s2;
		end
		if (done) begin
			out_q.point_count <= cnt_s3;
			if (total[64:48] != '0) begin
				out_q.intensity <= fppa_pkg::INTENSITY_MAX;
				out_q.saturated <= 1'b1;
			end else begin
				out_q.intensity <= total[47:0];
				out_q.saturated <= sat_s3;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
endmodule
`default_nettype wire

// ----- sv/fourier_phase_power_accumulator_unit.sv -----
// one point at a time: accept, phase product register, quadrant split register, CORDIC_STAGES rotator
// cells, rounding register, sum update; a point that is not last frees the input at its sum update,
// a last point when its result word leaves the three power stages for the output register
// the rotator cell chain sets the per-point time; the output register lets the next set start
// reset clears sums, count, wave vectors, scale to 65536 and all valid flags
`default_nettype none
module fourier_phase_power_accumulator_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [31:0]   cfg_data,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire fppa_pkg::in_t in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output fppa_pkg::out_t     out_data
);
	localparam int N = fppa_pkg::CORDIC_STAGES;

	logic signed [23:0] q_x_q, q_y_q;
	logic [31:0] scale_q;
	logic busy_q;
	logic accept;
	logic v_s1, last_s1;
	logic signed [39:0] px_s1, py_s1;
	logic [31:0] phase;
	logic [1:0] quad;
	logic [31:0] resid;
	fppa_pkg::cord_t chain [0:N];
	logic [N-1:0] cell_valid;
	logic v_r_q, last_r_q;
	logic signed [15:0] c_r_q, s_r_q;
	logic signed [17:0] c_rnd, s_rnd, c_rot, s_rot;
	logic signed [31:0] csum_q, ssum_q, csum_nxt, ssum_nxt;
	logic [fppa_pkg::COUNT_W-1:0] seen_q, seen_nxt;
	logic clip_q, clip_nxt;
	fppa_pkg::snap_t snap_q;
	logic res_done;

	assign accept = in_valid && !busy_q;
	assign in_stall = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_x_q <= '0;
			q_y_q <= '0;
			scale_q <= 32'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fppa_pkg::REG_Q_X: q_x_q <= cfg_data[23:0];
				fppa_pkg::REG_Q_Y: q_y_q <= cfg_data[23:0];
				fppa_pkg::REG_SCALE: scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// phase products, then quadrant split into the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1 <= 40'(q_x_q) * 40'(in_data.point_x);
			py_s1 <= 40'(q_y_q) * 40'(in_data.point_y);
			last_s1 <= in_data.is_last;
		end
	end

	assign phase = px_s1[31:0] + py_s1[31:0];
	assign quad = 2'((phase + 32'h2000_0000) >> 30);
	assign resid = phase - {quad, 30'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain[0] <= '0;
		end else begin
			chain[0].valid <= v_s1;
			chain[0].last <= last_s1;
			chain[0].quad <= quad;
			chain[0].x <= fppa_pkg::CORDIC_X0;
			chain[0].y <= '0;
			chain[0].z <= resid;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		fppa_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (5'(i)),
			.arc    (fppa_pkg::arc_at(i)),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
		assign cell_valid[i] = chain[i+1].valid;
	end

	// round to q1.15 and undo the quadrant
	always_comb begin
		c_rnd = 18'((chain[N].x + 32'sd16384) >>> 15);
		s_rnd = 18'((chain[N].y + 32'sd16384) >>> 15);
		unique case (chain[N].quad)
			fppa_pkg::QUAD_0: begin c_rot = c_rnd;  s_rot = s_rnd;  end
			fppa_pkg::QUAD_1: begin c_rot = -s_rnd; s_rot = c_rnd;  end
			fppa_pkg::QUAD_2: begin c_rot = -c_rnd; s_rot = -s_rnd; end
			fppa_pkg::QUAD_3: begin c_rot = s_rnd;  s_rot = -c_rnd; end
			default: begin c_rot = c_rnd; s_rot = s_rnd; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r_q <= 1'b0;
		end else begin
			v_r_q <= chain[N].valid;
		end
	end

	always_ff @(posedge clk) begin
		c_r_q <= fppa_pkg::clamp16(c_rot);
		s_r_q <= fppa_pkg::clamp16(s_rot);
		last_r_q <= chain[N].last;
	end

	// accumulate, dropping points once the set is full
	always_comb begin
		csum_nxt = csum_q;
		ssum_nxt = ssum_q;
		seen_nxt = seen_q;
		clip_nxt = clip_q;
		if (seen_q < fppa_pkg::COUNT_W'(fppa_pkg::MAX_POINTS)) begin
			csum_nxt = fppa_pkg::clamp32(33'(csum_q) + 33'(c_r_q));
			ssum_nxt = fppa_pkg::clamp32(33'(ssum_q) + 33'(s_r_q));
			seen_nxt = seen_q + 1'b1;
		end else begin
			clip_nxt = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csum_q <= '0;
			ssum_q <= '0;
			seen_q <= '0;
			clip_q <= 1'b0;
			snap_q <= '0;
		end else begin
			snap_q.valid <= 1'b0;
			if (v_r_q) begin
				if (last_r_q) begin
					snap_q.valid <= 1'b1;
					snap_q.c <= csum_nxt;
					snap_q.s <= ssum_nxt;
					snap_q.count <= seen_nxt;
					snap_q.sat <= clip_nxt;
					csum_q <= '0;
					ssum_q <= '0;
					seen_q <= '0;
					clip_q <= 1'b0;
				end else begin
					csum_q <= csum_nxt;
					ssum_q <= ssum_nxt;
					seen_q <= seen_nxt;
					clip_q <= clip_nxt;
				end
			end
		end
	end

	fppa_power u_power (
		.clk       (clk),
		.arst_n    (arst_n),
		.snap      (snap_q),
		.scale     (scale_q),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.done      (res_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if ((v_r_q && !last_r_q) || res_done) begin
			busy_q <= 1'b0;
		end
	end

	a_one_word_in_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_valid))
		else $error("more than one word in the rotator chain");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= fppa_pkg::COUNT_W'(fppa_pkg::MAX_POINTS))
		else $error("point count beyond the set limit");

	a_snap_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		snap_q.valid |-> ($past(v_r_q) && $past(last_r_q)))
		else $error("set closed without a last point");

	a_busy_during_work: assert property (@(posedge clk) disable iff (!arst_n)
		(chain[N].valid || v_r_q || snap_q.valid) |-> busy_q)
		else $error("input freed while a point is in flight");
endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// self-checking testbench for the phase power accumulator: directed sets, then random sets
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           cfg_we = 1'b0;
	logic [1:0]     cfg_index = fppa_pkg::REG_Q_X;
	logic [31:0]    cfg_data = '0;
	logic           in_valid = 1'b0;
	logic           in_stall;
	fppa_pkg::in_t  in_data = '0;
	logic           out_valid;
	logic           out_stall = 1'b0;
	fppa_pkg::out_t out_data;

	fppa_pkg::in_t  pending_words[$];
	fppa_pkg::out_t expected_sums[$];
	int   idle_pct = 35;
	bit   hold_input = 1'b0;
	int   fail_count = 0;

	// mirrored configuration and accumulator state
	logic signed [23:0] wave_x = '0;
	logic signed [23:0] wave_y = '0;
	logic [31:0]        power_scale = 32'd65536;
	longint             cos_acc = 0;
	longint             sin_acc = 0;
	int                 held_points = 0;
	bit                 points_dropped = 1'b0;

	fourier_phase_power_accumulator_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint sat_range(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// rotate the gain-compensated unit vector to the phase, giving cos and sin in Q1.15
	function automatic void rotate_phase(input logic [31:0] phase, output longint c,
			output longint s);
		logic [1:0]  quad;
		logic [31:0] resid;
		longint      x, y, z, dx, dy, t;
		quad = 2'((phase + 32'h2000_0000) >> 30);
		resid = phase - {quad, 30'd0};
		z = longint'($signed(resid));
		x = 652032874;
		y = 0;
		for (int i = 0; i < fppa_pkg::CORDIC_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(fppa_pkg::arc_at(i));
			end else begin
				x += dx; y -= dy; z += longint'(fppa_pkg::arc_at(i));
			end
		end
		c = (x + 16384) >>> 15;
		s = (y + 16384) >>> 15;
		case (quad)
			fppa_pkg::QUAD_1: begin t = c; c = -s; s = t; end
			fppa_pkg::QUAD_2: begin c = -c; s = -s; end
			fppa_pkg::QUAD_3: begin t = c; c = s; s = -t; end
			default: ;
		endcase
		c = sat_range(c, -32768, 32767);
		s = sat_range(s, -32768, 32767);
	endfunction

	task automatic accumulate_point(input fppa_pkg::in_t w);
		longint         prod, c, s;
		logic [63:0]    mag, inten;
		fppa_pkg::out_t r;
		prod = longint'(wave_x) * longint'(w.point_x) + longint'(wave_y) * longint'(w.point_y);
		if (held_points < fppa_pkg::MAX_POINTS) begin
			rotate_phase(prod[31:0], c, s);
			cos_acc = sat_range(cos_acc + c, -64'sd2147483648, 64'sd2147483647);
			sin_acc = sat_range(sin_acc + s, -64'sd2147483648, 64'sd2147483647);
			held_points++;
		end else
			points_dropped = 1'b1;
		if (w.is_last) begin
			mag = cos_acc * cos_acc + sin_acc * sin_acc;
			inten = 64'(mag[63:32]) * power_scale + ((64'(mag[31:0]) * power_scale) >> 32);
			r.saturated = points_dropped;
			if (inten > 64'(fppa_pkg::INTENSITY_MAX)) begin
				inten = 64'(fppa_pkg::INTENSITY_MAX);
				r.saturated = 1'b1;
			end
			r.intensity = inten[47:0];
			r.point_count = fppa_pkg::COUNT_W'(held_points);
			expected_sums.push_back(r);
			cos_acc = 0;
			sin_acc = 0;
			held_points = 0;
			points_dropped = 1'b0;
		end
	endtask

	// driver: present the next word once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) accumulate_point(in_data);
			if (pending_words.size() > 0 && !hold_input && $urandom_range(99) >= idle_pct) begin
				in_data <= pending_words.pop_front();
				in_valid <= 1'b1;
			end else
				in_valid <= 1'b0;
		end
	end

	// monitor: compare each accepted result word with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		fppa_pkg::out_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_sums.size() == 0) begin
					$display("%t unexpected word: expected none actual %h", $realtime,
						out_data);
					fail_count++;
				end else begin
					want = expected_sums.pop_front();
					if (out_data.intensity !== want.intensity) begin
						$display("%t intensity: expected %h actual %h", $realtime,
							want.intensity, out_data.intensity);
						fail_count++;
					end
					if (out_data.point_count !== want.point_count) begin
						$display("%t point_count: expected %0d actual %0d", $realtime,
							want.point_count, out_data.point_count);
						fail_count++;
					end
					if (out_data.saturated !== want.saturated) begin
						$display("%t saturated: expected %b actual %b", $realtime,
							want.saturated, out_data.saturated);
						fail_count++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	task automatic add_point(input int x, input int y, input bit last);
		fppa_pkg::in_t w;
		w.point_x = 16'(x);
		w.point_y = 16'(y);
		w.is_last = last;
		pending_words.push_back(w);
	endtask

	// wait for every word to be taken and every result to arrive, then let the pipe empty
	task automatic drain();
		while (pending_words.size() > 0 || in_valid || expected_sums.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			fppa_pkg::REG_Q_X: wave_x = value[23:0];
			fppa_pkg::REG_Q_Y: wave_y = value[23:0];
			default: power_scale = value;
		endcase
	endtask

	task automatic write_all(input int qx, input int qy, input logic [31:0] scale);
		write_reg(fppa_pkg::REG_Q_X, 32'(qx));
		write_reg(fppa_pkg::REG_Q_Y, 32'(qy));
		write_reg(fppa_pkg::REG_SCALE, scale);
	endtask

	function automatic int rand_coord();
		case ($urandom_range(7))
			0: return -32768;
			1: return 32767;
			2: return int'($urandom_range(16)) - 8;
			default: return int'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	function automatic int rand_wave();
		case ($urandom_range(7))
			0: return -8388608;
			1: return 8388607;
			2: return int'($urandom_range(4096)) - 2048;
			default: return int'($urandom_range(16777215)) - 8388608;
		endcase
	endfunction

	initial begin
		int len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: zero wave vector, single points and a short set; then extreme wave vectors
		add_point(0, 0, 1);
		add_point(-32768, 32767, 1);
		add_point(5, -5, 0);
		add_point(7, 9, 1);
		drain();
		write_all(8388607, -8388608, 32'hFFFF_FFFF);
		add_point(32767, 32767, 1);
		add_point(-32768, -32768, 1);
		add_point(32767, -32768, 0);
		add_point(-32768, 32767, 0);
		add_point(1, 1, 1);
		add_point(0, 0, 1);
		drain();
		write_all(-8388608, 8388607, 32'd0);
		add_point(12345, -321, 0);
		add_point(-32768, 32767, 1);
		drain();

		// long coherent set at zero phase: max scale clips the intensity
		idle_pct = 0;
		write_all(0, 0, 32'hFFFF_FFFF);
		for (int i = 0; i < 530; i++)
			add_point(rand_coord(), rand_coord(), i == 529);
		drain();

		for (int phase_i = 0; phase_i < 12; phase_i++) begin
			idle_pct = (phase_i == 4) ? 0 : 35;
			case (phase_i % 4)
				0: write_all(rand_wave(), rand_wave(), 32'($urandom()));
				1: write_all(rand_wave(), rand_wave(), 32'd65536);
				2: write_all(rand_wave(), 0, 32'hFFFF_FFFF);
				default: write_all(rand_wave(), rand_wave(), 32'($urandom_range(1 << 20)));
			endcase
			for (int n = 0; n < 50; n += len) begin
				len = ($urandom_range(9) == 0) ? int'($urandom_range(40, 12))
					: int'($urandom_range(6, 1));
				for (int k = 0; k < len; k++)
					add_point(rand_coord(), rand_coord(), k == len - 1);
			end
			// sender holds back until every result has come
			if (phase_i == 6) begin
				while (pending_words.size() > 30) @(posedge clk);
				hold_input = 1'b1;
				while (in_valid || expected_sums.size() > 0) @(posedge clk);
				hold_input = 1'b0;
			end
			drain();
		end

		if (fail_count == 0)
			$display("fourier_phase_power_accumulator_unit regression: pass");
		else
			$display("fourier_phase_power_accumulator_unit regression: fail");
		$finish;
	end

	initial begin
		#10ms;
		$display("fourier_phase_power_accumulator_unit regression: fail");
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
sv/fppa_pkg.sv
sv/fppa_cell.sv
sv/fppa_power.sv
sv/fourier_phase_power_accumulator_unit.sv
test/testbench.sv
